// ----- design/ppfa_pkg.sv -----
// ----------------------------------------------------------------------------
// ppfa_pkg
// Shared widths, status and register codes and the configuration view type
// for the physical page frame allocator.
// ----------------------------------------------------------------------------
package ppfa_pkg;

   localparam int PAGE_W      = 13;   // page index and page count width
   localparam int ADDR_W      = 32;   // byte address width
   localparam int PAGE_SHIFT  = 12;   // 4 KiB pages
   localparam int STATUS_W    = 3;
   localparam int WORD_BITS   = 32;   // used marks per memory word
   localparam int OFF_W       = 5;    // bit offset inside a word
   localparam int WIDX_W      = PAGE_W - OFF_W;
   localparam int PAGE_LIMIT  = 8192; // indices reachable with PAGE_W bits
   localparam int CSR_IDX_W   = 2;

   // Result status codes
   localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_OOM        = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_MISALIGNED = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_RANGE      = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_NOT_USED   = 3'd4;

   // Request function codes
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_PAGE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_COUNT = 2'd1;

   localparam logic [PAGE_W-1:0] FIRST_PAGE_RESET = 13'd0;
   localparam logic [PAGE_W-1:0] PAGE_COUNT_RESET = 13'd4096;

   typedef struct packed {
      logic [PAGE_W-1:0] first_page;
      logic [PAGE_W-1:0] scan_end;
   } cfg_view_type;

endpackage

// ----- design/ppfa_bitmap_mem.sv -----
// ----------------------------------------------------------------------------
// ppfa_bitmap_mem
// Used-mark store: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module ppfa_bitmap_mem
   import ppfa_pkg::*;
#(
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [WORD_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/ppfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// ppfa_ctrl
// Request sequencer: clears the store after reset, scans words for the
// first free page, checks and clears marks on free, and drives the result
// register.
// ----------------------------------------------------------------------------
module ppfa_ctrl
   import ppfa_pkg::*;
#(
   parameter int MEM_WORDS = 128,
   parameter int MEM_AW    = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_view_type         cfg,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_func,
   input  logic [ADDR_W-1:0]    req_page_address,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [ADDR_W-1:0]    rsp_granted_address,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [PAGE_W-1:0]    rsp_free_count,
   output logic                 mem_wr_en,
   output logic [MEM_AW-1:0]    mem_wr_addr,
   output logic [WORD_BITS-1:0] mem_wr_data,
   output logic                 mem_rd_en,
   output logic [MEM_AW-1:0]    mem_rd_addr,
   input  logic [WORD_BITS-1:0] mem_rd_data
);

   localparam int IDX_W = ADDR_W - PAGE_SHIFT;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_ALLOC = 3'd2;
   localparam logic [2:0] S_FREE  = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   localparam logic [MEM_AW-1:0] CLEAR_LAST = MEM_AW'(MEM_WORDS - 1);

   logic [2:0]           state_ff, state_in;
   logic [MEM_AW-1:0]    clr_addr_ff, clr_addr_in;
   logic [WIDX_W-1:0]    word_ff, word_in;
   logic [OFF_W-1:0]     bit_ff, bit_in;
   logic [PAGE_W-1:0]    used_ff, used_in;
   logic [ADDR_W-1:0]    res_addr_ff, res_addr_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]    rsp_addr_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [PAGE_W-1:0]    rsp_free_ff;

   logic [IDX_W-1:0]     free_idx;
   logic                 misaligned;
   logic                 range_bad;
   logic                 no_span;
   logic                 out_free;
   logic [WORD_BITS-1:0] lo_mask, hi_mask, cand, bit_onehot;
   logic                 hit;
   logic [OFF_W-1:0]     hit_bit;
   logic [WIDX_W:0]      next_word;
   logic                 last_word;
   logic [PAGE_W-1:0]    span;
   logic [PAGE_W-1:0]    free_now;

   // Lowest set bit: pick the lowest nonzero byte, then the bit inside it
   function automatic logic [OFF_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
      logic [1:0] byte_sel;
      logic [7:0] byte_val;
      logic [2:0] bit_sel;
      byte_sel = 2'd0;
      bit_sel  = 3'd0;
      for (int b = 3; b >= 0; b--) begin
         if (|v[b*8 +: 8]) begin
            byte_sel = 2'(b);
         end
      end
      byte_val = v[byte_sel*8 +: 8];
      for (int i = 7; i >= 0; i--) begin
         if (byte_val[i]) begin
            bit_sel = 3'(i);
         end
      end
      return {byte_sel, bit_sel};
   endfunction

   assign free_idx   = req_page_address[ADDR_W-1:PAGE_SHIFT];
   assign misaligned = |req_page_address[PAGE_SHIFT-1:0];
   assign range_bad  = (free_idx < {{(IDX_W-PAGE_W){1'b0}}, cfg.first_page}) ||
                       (free_idx >= {{(IDX_W-PAGE_W){1'b0}}, cfg.scan_end});
   assign no_span    = cfg.first_page >= cfg.scan_end;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Allocatable pages within the word under scan
   assign lo_mask   = (word_ff == cfg.first_page[PAGE_W-1:OFF_W]) ?
                      ({WORD_BITS{1'b1}} << cfg.first_page[OFF_W-1:0]) : {WORD_BITS{1'b1}};
   assign hi_mask   = (word_ff == cfg.scan_end[PAGE_W-1:OFF_W]) ?
                      ~({WORD_BITS{1'b1}} << cfg.scan_end[OFF_W-1:0]) : {WORD_BITS{1'b1}};
   assign cand      = ~mem_rd_data & lo_mask & hi_mask;
   assign hit       = |cand;
   assign hit_bit   = lowest_set(cand);
   assign next_word = {1'b0, word_ff} + 1'b1;
   assign last_word = {next_word, {OFF_W{1'b0}}} >= {1'b0, cfg.scan_end};

   assign bit_onehot = WORD_BITS'(1) << (state_ff == S_ALLOC ? hit_bit : bit_ff);

   // Free count after this request, saturated at zero
   assign span     = cfg.scan_end - cfg.first_page;
   assign free_now = (no_span || used_ff >= span) ? '0 : span - used_ff;

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      word_in       = word_ff;
      bit_in        = bit_ff;
      used_in       = used_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = word_ff[MEM_AW-1:0];
      mem_wr_data   = '0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = word_ff[MEM_AW-1:0];

      unique case (state_ff)
         S_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == CLEAR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               res_addr_in = '0;
               if (req_func == FUNC_ALLOC) begin
                  if (no_span) begin
                     res_status_in = STAT_OOM;
                     state_in      = S_OUT;
                  end else begin
                     word_in     = cfg.first_page[PAGE_W-1:OFF_W];
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = cfg.first_page[OFF_W +: MEM_AW];
                     state_in    = S_ALLOC;
                  end
               end else begin
                  priority if (misaligned) begin
                     res_status_in = STAT_MISALIGNED;
                     state_in      = S_OUT;
                  end else if (range_bad) begin
                     res_status_in = STAT_RANGE;
                     state_in      = S_OUT;
                  end else begin
                     word_in     = free_idx[PAGE_W-1:OFF_W];
                     bit_in      = free_idx[OFF_W-1:0];
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = free_idx[OFF_W +: MEM_AW];
                     state_in    = S_FREE;
                  end
               end
            end
         end
         S_ALLOC: begin
            priority if (hit) begin
               mem_wr_en     = 1'b1;
               mem_wr_data   = mem_rd_data | bit_onehot;
               used_in       = used_ff + 1'b1;
               res_addr_in   = ADDR_W'({word_ff, hit_bit}) << PAGE_SHIFT;
               res_status_in = STAT_OK;
               state_in      = S_OUT;
            end else if (last_word) begin
               res_status_in = STAT_OOM;
               state_in      = S_OUT;
            end else begin
               // Advance to the next word; its data arrives next cycle
               word_in     = next_word[WIDX_W-1:0];
               mem_rd_en   = 1'b1;
               mem_rd_addr = next_word[MEM_AW-1:0];
            end
         end
         S_FREE: begin
            if (|(mem_rd_data & bit_onehot)) begin
               mem_wr_en     = 1'b1;
               mem_wr_data   = mem_rd_data & ~bit_onehot;
               used_in       = (used_ff != '0) ? used_ff - 1'b1 : used_ff;
               res_status_in = STAT_OK;
            end else begin
               res_status_in = STAT_NOT_USED;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (state_ff == S_OUT && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff       <= word_in;
      bit_ff        <= bit_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      if (state_ff == S_OUT && out_free) begin
         rsp_addr_ff   <= res_addr_ff;
         rsp_status_ff <= res_status_ff;
         rsp_free_ff   <= free_now;
      end
   end

   assign req_stall           = state_ff != S_IDLE;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_free_count      = rsp_free_ff;

endmodule

// ----- design/physical_page_frame_allocator_core.sv -----
// ----------------------------------------------------------------------------
// physical_page_frame_allocator_core
// First-fit physical page frame allocator over a one-bit-per-page used store.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): req_func selects allocate or free; req_page_address
//   names the page to free. A transfer takes place when req_valid is high and
//   req_stall is low. One request is in work at a time.
//   Result channel (rsp_*): exactly one result per request, with the granted
//   address (0 unless an allocate succeeds), a status code and the number of
//   free pages after the request. A result register parts the two sides, so
//   the next request is taken while a result waits for the receiver.
//   Sequence: a free reads the used word, then checks and writes back; a free
//   that fails the alignment or range check and an allocate with an empty page
//   range go straight to the result step. An allocate reads one 32-page word
//   at a time through the single read port of the used store until it finds a
//   free page or passes the end of the range.
//   The next request can be taken in the cycle after the result is loaded.
//   Reset: config registers return to their reset values, then a clearing
//   pass writes zero to every one of the ceil(min(MAX_PAGES, 8192)/32) store
//   words (128 at the default), one word a cycle; req_stall stays high
//   meanwhile. Config writes are taken at any time.
//   Stall: while rsp_stall holds a result, a finished request waits in its
//   last step and req_stall stays high.
// ----------------------------------------------------------------------------
module physical_page_frame_allocator_core
   import ppfa_pkg::*;
#(
   parameter int MAX_PAGES = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PAGE_W-1:0]    csr_wdata,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_func,
   input  logic [ADDR_W-1:0]    req_page_address,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [ADDR_W-1:0]    rsp_granted_address,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [PAGE_W-1:0]    rsp_free_count
);

   // Pages beyond the reach of a 13-bit page count are never addressed
   localparam int PAGES     = (MAX_PAGES < PAGE_LIMIT) ? MAX_PAGES : PAGE_LIMIT;
   localparam int MEM_WORDS = (PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int MEM_AW    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
   localparam logic [PAGE_W:0] PAGES_CLIP = (PAGE_W + 1)'(PAGES);

   logic [PAGE_W-1:0]    first_page_ff, first_page_in;
   logic [PAGE_W-1:0]    page_count_ff, page_count_in;
   cfg_view_type         cfg;

   logic                 mem_wr_en;
   logic [MEM_AW-1:0]    mem_wr_addr;
   logic [WORD_BITS-1:0] mem_wr_data;
   logic                 mem_rd_en;
   logic [MEM_AW-1:0]    mem_rd_addr;
   logic [WORD_BITS-1:0] mem_rd_data;

   // Register writes; an index beyond the two registers is dropped
   always_comb begin
      first_page_in = first_page_ff;
      page_count_in = page_count_ff;
      if (csr_wr_en) begin
         if (csr_index == CSR_FIRST_PAGE) begin
            first_page_in = csr_wdata;
         end
         if (csr_index == CSR_PAGE_COUNT) begin
            page_count_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_page_ff <= FIRST_PAGE_RESET;
         page_count_ff <= PAGE_COUNT_RESET;
      end else begin
         first_page_ff <= first_page_in;
         page_count_ff <= page_count_in;
      end
   end

   // Scan end is the page count clipped to the store size
   assign cfg.first_page = first_page_ff;
   assign cfg.scan_end   = ({1'b0, page_count_ff} > PAGES_CLIP) ?
                           PAGES_CLIP[PAGE_W-1:0] : page_count_ff;

   ppfa_ctrl #(
      .MEM_WORDS (MEM_WORDS),
      .MEM_AW    (MEM_AW)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_func),
      .req_page_address    (req_page_address),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_granted_address (rsp_granted_address),
      .rsp_status          (rsp_status),
      .rsp_free_count      (rsp_free_count),
      .mem_wr_en           (mem_wr_en),
      .mem_wr_addr         (mem_wr_addr),
      .mem_wr_data         (mem_wr_data),
      .mem_rd_en           (mem_rd_en),
      .mem_rd_addr         (mem_rd_addr),
      .mem_rd_data         (mem_rd_data)
   );

   ppfa_bitmap_mem #(
      .DEPTH (MEM_WORDS),
      .AW    (MEM_AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit page frame allocator core. A local
// predictor keeps its own copy of the used marks, the used count and the two
// window registers, works out the result of every request at its transfer
// and checks each result transfer in order. Directed requests cover the
// error paths, out of memory, free count saturation and the register
// extremes. Random phases over several windows follow, with bursts of
// idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
   import ppfa_pkg::*;

   localparam int FRAMES      = 4096;  // MAX_PAGES of the instance
   localparam int QUIET_LIMIT = 3000;  // cycles without any transfer
   localparam int DRAIN_TAIL  = 140;   // longest allocate scan plus margin
   localparam int LONG_HOLD   = 320;   // receiver hold-off length

   // Indexes beyond the two registers; writes to them must do nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct {
      logic [ADDR_W-1:0]   granted;
      logic [STATUS_W-1:0] status;
      logic [PAGE_W-1:0]   free_cnt;
   } frame_result_type;

   // Predicts the allocator and holds the results still owed by the block
   class frame_scoreboard;
      bit               page_taken [FRAMES];
      int unsigned      taken_total;
      int unsigned      first_pg;
      int unsigned      page_cnt;
      frame_result_type awaited[$];
      int unsigned      held_pages[$];
      int unsigned      fail_count;

      function new();
         first_pg    = FIRST_PAGE_RESET;
         page_cnt    = PAGE_COUNT_RESET;
         taken_total = 0;
         fail_count  = 0;
         foreach (page_taken[i]) page_taken[i] = 1'b0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [PAGE_W-1:0] data);
         case (idx)
            CSR_FIRST_PAGE: first_pg = data;
            CSR_PAGE_COUNT: page_cnt = data;
            default: ;
         endcase
      endfunction

      function int unsigned scan_limit();
         return (page_cnt > FRAMES) ? FRAMES : page_cnt;
      endfunction

      // Free pages in the window; saturate at zero when the window shrank
      function logic [PAGE_W-1:0] free_now();
         int unsigned lim;
         lim = scan_limit();
         if (lim <= first_pg) return '0;
         if (taken_total >= lim - first_pg) return '0;
         return PAGE_W'(lim - first_pg - taken_total);
      endfunction

      function void drop_held(int unsigned page);
         for (int i = 0; i < held_pages.size(); i++) begin
            if (held_pages[i] == page) begin
               held_pages.delete(i);
               return;
            end
         end
      endfunction

      function void note_request(logic func, logic [ADDR_W-1:0] addr);
         frame_result_type r;
         int unsigned      lim;
         int unsigned      page;
         lim          = scan_limit();
         r.granted    = '0;
         r.status     = STAT_OK;
         if (func == FUNC_ALLOC) begin
            r.status = STAT_OOM;
            for (int unsigned i = first_pg; i < lim; i++) begin
               if (!page_taken[i]) begin
                  page_taken[i] = 1'b1;
                  taken_total++;
                  r.granted = ADDR_W'(i) << PAGE_SHIFT;
                  r.status  = STAT_OK;
                  held_pages.push_back(i);
                  break;
               end
            end
         end else begin
            page = addr >> PAGE_SHIFT;
            if (addr[PAGE_SHIFT-1:0] != '0) begin
               r.status = STAT_MISALIGNED;
            end else if (page < first_pg || page >= lim) begin
               r.status = STAT_RANGE;
            end else if (!page_taken[page]) begin
               r.status = STAT_NOT_USED;
            end else begin
               page_taken[page] = 1'b0;
               if (taken_total > 0) taken_total--;
               drop_held(page);
            end
         end
         r.free_cnt = free_now();
         awaited.push_back(r);
      endfunction

      task report(string what);
         fail_count++;
         $display("[%0t] MISMATCH: %s", $time, what);
      endtask

      task check_result(logic [ADDR_W-1:0] granted, logic [STATUS_W-1:0] status,
                        logic [PAGE_W-1:0] free_cnt);
         frame_result_type want;
         if (awaited.size() == 0) begin
            report($sformatf("result with nothing outstanding: addr=%h status=%0d free=%0d",
                             granted, status, free_cnt));
            return;
         end
         want = awaited.pop_front();
         if (granted !== want.granted)
            report($sformatf("granted_address %h, want %h", granted, want.granted));
         if (status !== want.status)
            report($sformatf("status %0d, want %0d", status, want.status));
         if (free_cnt !== want.free_cnt)
            report($sformatf("free_count %0d, want %0d", free_cnt, want.free_cnt));
      endtask
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [PAGE_W-1:0]    csr_wdata;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_func;
   logic [ADDR_W-1:0]    req_page_address;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [ADDR_W-1:0]    rsp_granted_address;
   logic [STATUS_W-1:0]  rsp_status;
   logic [PAGE_W-1:0]    rsp_free_count;

   frame_scoreboard sb;
   bit              sender_idling;
   bit              receiver_idling;
   bit              hold_request;

   physical_page_frame_allocator_core #(
      .MAX_PAGES(FRAMES)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_page_address   (req_page_address),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_granted_address(rsp_granted_address),
      .rsp_status         (rsp_status),
      .rsp_free_count     (rsp_free_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Offer one request and hold it until the transfer; then either keep valid
   // high for the next request or drop it for a random gap.
   task automatic push_request(logic func, logic [ADDR_W-1:0] addr);
      req_valid        <= 1'b1;
      req_func         <= func;
      req_page_address <= addr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(func, addr);
      if (sender_idling && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   // Stop offering and wait for every owed result to come back
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [PAGE_W-1:0] data, bit last);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.set_register(idx, data);
      if (last) csr_wr_en <= 1'b0;
   endtask

   // Move the allocatable window; only done with the block idle. Optionally
   // also hit the unused indexes, which must leave both registers alone.
   task automatic set_window(int unsigned first_val, int unsigned count_val, bit poke_spare);
      drain();
      write_csr(CSR_FIRST_PAGE, PAGE_W'(first_val), 1'b0);
      write_csr(CSR_PAGE_COUNT, PAGE_W'(count_val), !poke_spare);
      if (poke_spare) begin
         write_csr(CSR_SPARE_2, PAGE_W'($urandom_range(0, 8191)), 1'b0);
         write_csr(CSR_SPARE_3, PAGE_W'($urandom_range(0, 8191)), 1'b1);
      end
   endtask

   // Mostly well-formed traffic: allocations and frees of pages actually
   // held, plus frees near the window edges, misaligned and wild addresses.
   task automatic random_burst(int unsigned n);
      int unsigned pick;
      int unsigned page;
      int unsigned lo;
      int unsigned hi;
      int unsigned alloc_share;
      for (int unsigned k = 0; k < n; k++) begin
         lo          = sb.first_pg;
         hi          = sb.scan_limit();
         // keep the used marks sparse so scans stay short
         alloc_share = (sb.held_pages.size() > 160) ? 25 : 45;
         pick        = $urandom_range(0, 99);
         if (pick < alloc_share || (pick < 75 && sb.held_pages.size() == 0)) begin
            push_request(FUNC_ALLOC, $urandom());
         end else if (pick < 75) begin
            page = sb.held_pages[$urandom_range(0, sb.held_pages.size() - 1)];
            push_request(FUNC_FREE, ADDR_W'(page) << PAGE_SHIFT);
         end else if (pick < 84) begin
            if (lo > FRAMES) lo = FRAMES;
            page = $urandom_range((lo > 4) ? lo - 4 : 0, hi + 4);
            push_request(FUNC_FREE, ADDR_W'(page) << PAGE_SHIFT);
         end else if (pick < 91) begin
            page = $urandom_range(0, FRAMES + 8);
            push_request(FUNC_FREE, (ADDR_W'(page) << PAGE_SHIFT) |
                                    ADDR_W'($urandom_range(1, 4095)));
         end else begin
            push_request(FUNC_FREE, $urandom());
         end
      end
   endtask

   // Result side: check every transfer, stall in random bursts, and take the
   // long hold-off when the stimulus asks for it.
   initial begin
      int unsigned stall_left;
      rsp_stall  = 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_granted_address, rsp_status, rsp_free_count);
         if (stall_left > 0) begin
            stall_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = LONG_HOLD;
         end else if (receiver_idling && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 19);
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   // Watchdog: end the run when no transfer happens on either side too long
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      sb               = new();
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_index        = CSR_FIRST_PAGE;
      csr_wdata        = '0;
      req_valid        = 1'b0;
      req_func         = FUNC_ALLOC;
      req_page_address = '0;
      sender_idling    = 1'b1;
      receiver_idling  = 1'b1;
      hold_request     = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Full window: basic grants, every free error, boundary addresses
      set_window(0, 4096, 1'b0);
      push_request(FUNC_ALLOC, 32'hFFFF_FFFF);
      push_request(FUNC_ALLOC, 32'h0000_0000);
      push_request(FUNC_ALLOC, 32'h0000_0000);
      push_request(FUNC_FREE,  32'h0000_1000);
      push_request(FUNC_FREE,  32'h0000_1000);   // already free
      push_request(FUNC_FREE,  32'h0000_1001);   // misaligned
      push_request(FUNC_FREE,  32'hFFFF_FFFF);   // misaligned wins over range
      push_request(FUNC_FREE,  32'hFFFF_F000);   // far out of range
      push_request(FUNC_FREE,  32'h0100_0000);   // first index past the end
      push_request(FUNC_FREE,  32'h00FF_F000);   // last page, never used
      push_request(FUNC_ALLOC, 32'h0000_0000);   // refill the lowest hole

      // Window shrunk below the used count: free count saturates at zero
      set_window(0, 2, 1'b0);
      push_request(FUNC_ALLOC, 32'h0000_0000);
      push_request(FUNC_FREE,  32'h0000_2000);
      push_request(FUNC_FREE,  32'h0000_0000);

      // Top of the store, count register past the store size: run out
      set_window(4094, 8191, 1'b0);
      push_request(FUNC_ALLOC, 32'h0000_0000);
      push_request(FUNC_ALLOC, 32'h0000_0000);
      push_request(FUNC_ALLOC, 32'h0000_0000);
      push_request(FUNC_FREE,  32'h00FF_D000);   // below first page
      push_request(FUNC_FREE,  32'h00FF_E000);
      push_request(FUNC_FREE,  32'h00FF_F000);

      // Empty window; unused indexes written too
      set_window(8191, 0, 1'b1);
      push_request(FUNC_ALLOC, 32'h0000_0000);
      push_request(FUNC_FREE,  32'h0000_0000);

      // Random phases. In the first one, hold off the receiver while requests
      // keep coming so the block backs up, then pause until all results land.
      set_window(0, 4096, 1'b0);
      random_burst(60);
      hold_request = 1'b1;
      random_burst(40);
      drain();
      random_burst(50);
      set_window(100, 140, 1'b1);
      random_burst(100);
      set_window(4000, 8191, 1'b0);
      random_burst(80);
      set_window(8191, 8191, 1'b0);
      random_burst(20);
      set_window(0, 0, 1'b1);
      random_burst(20);
      set_window(3000, 3040, 1'b0);
      random_burst(80);

      // Last stretch at full rate on both sides
      set_window(0, 4096, 1'b0);
      sender_idling   = 1'b0;
      receiver_idling = 1'b0;
      random_burst(200);

      drain();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (sb.fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
